>>> sv/cff_pkg.sv
// shared types and constants for the causal fir filter unit
package cff_pkg;

    localparam int TAPS      = 8;
    localparam int MAX_TAPS  = 8;
    localparam int NUM_COEF  = 8;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int SUM1_W    = PROD_W + 1;
    localparam int SUM2_W    = PROD_W + 2;
    localparam int OUT_W     = PROD_W + 3;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [SUM1_W-1:0]   sum1_t;
    typedef logic signed [SUM2_W-1:0]   sum2_t;
    typedef logic signed [OUT_W-1:0]    out_t;

    typedef struct packed {
        logic load;
        logic clear;
    } cell_ctrl_t;

endpackage

>>> sv/cff_in_if.sv
// sample channel interface
interface cff_in_if
    import cff_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t sample;
    logic    last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink (input valid, input sample, input last_sample, output ready);
endinterface

>>> sv/cff_out_if.sv
// result channel interface
interface cff_out_if
    import cff_pkg::*;
;
    logic valid;
    logic ready;
    out_t filtered;
    logic last_out;

    modport source (output valid, output filtered, output last_out, input ready);
    modport sink (input valid, input filtered, input last_out, output ready);
endinterface

>>> sv/cff_tap_cell.sv
// one tap cell: delay register and registered coefficient product
module cff_tap_cell
    import cff_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  sample_t    tap_x,
    input  coef_t      coef,
    output sample_t    samp,
    output prod_t      prod
);

    sample_t samp_reg;
    sample_t samp_next;
    prod_t   prod_reg;
    prod_t   prod_next;

    always_comb
    begin
        samp_next = samp_reg;
        prod_next = prod_reg;
        if (ctrl.load)
        begin
            prod_next = PROD_W'(tap_x) * PROD_W'(coef);
            if (ctrl.clear)
            begin
                samp_next = '0;
            end
            else
            begin
                samp_next = tap_x;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samp_reg <= '0;
        end
        else
        begin
            samp_reg <= samp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign samp = samp_reg;
    assign prod = prod_reg;

endmodule

>>> sv/cff_add_tree.sv
// registered adder tree with per-stage flow control and output register
module cff_add_tree
    import cff_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  prod_t            prod [MAX_TAPS],
    input  logic             prod_valid,
    input  logic             prod_last,
    output logic             prod_en,
    cff_out_if.source        results
);

    sum1_t s1_reg [MAX_TAPS/2];
    sum1_t s1_next [MAX_TAPS/2];
    sum2_t s2_reg [MAX_TAPS/4];
    sum2_t s2_next [MAX_TAPS/4];
    out_t  out_reg;
    out_t  out_next;
    logic  v1_reg, v1_next, l1_reg, l1_next;
    logic  v2_reg, v2_next, l2_reg, l2_next;
    logic  vo_reg, vo_next, lo_reg, lo_next;
    logic  en1, en2, en3;

    assign en3     = !vo_reg || results.ready;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign prod_en = en1;

    always_comb
    begin
        for (int k = 0; k < MAX_TAPS/2; k++)
        begin
            s1_next[k] = en1 ? (SUM1_W'(prod[2*k]) + SUM1_W'(prod[2*k+1])) : s1_reg[k];
        end
        for (int k = 0; k < MAX_TAPS/4; k++)
        begin
            s2_next[k] = en2 ? (SUM2_W'(s1_reg[2*k]) + SUM2_W'(s1_reg[2*k+1])) : s2_reg[k];
        end
        out_next = en3 ? (OUT_W'(s2_reg[0]) + OUT_W'(s2_reg[1])) : out_reg;
        v1_next  = en1 ? prod_valid : v1_reg;
        l1_next  = en1 ? prod_last  : l1_reg;
        v2_next  = en2 ? v1_reg     : v2_reg;
        l2_next  = en2 ? l1_reg     : l2_reg;
        vo_next  = en3 ? v2_reg     : vo_reg;
        lo_next  = en3 ? l2_reg     : lo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            vo_reg <= vo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg  <= s1_next;
        s2_reg  <= s2_next;
        out_reg <= out_next;
        l1_reg  <= l1_next;
        l2_reg  <= l2_next;
        lo_reg  <= lo_next;
    end

    assign results.valid    = vo_reg;
    assign results.filtered = out_reg;
    assign results.last_out = lo_reg;

endmodule

>>> sv/causal_fir_filter_unit.sv
// causal direct-form fir filter top level
// products load at the transfer, then pass the pair-sum, quad-sum and output registers
// throughput: one sample per cycle; each stage holds while its successor is full
// the tap cell row multiplies all taps in parallel and the adder tree sums them
// reset clears coefficients, the delay line and all stage valid flags
module causal_fir_filter_unit
    import cff_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data,
    cff_in_if.sink               samples,
    cff_out_if.source            results
);

    coef_t      coef_reg [NUM_COEF];
    coef_t      coef_next [NUM_COEF];
    sample_t    tap_x [TAPS+1];
    prod_t      cell_prod [TAPS];
    prod_t      tree_in [MAX_TAPS];
    cell_ctrl_t ctrl;
    logic       accept;
    logic       prod_en;
    logic       pv_reg, pv_next;
    logic       pl_reg, pl_next;

    assign samples.ready = prod_en;
    assign accept        = samples.valid && prod_en;
    assign ctrl.load     = accept;
    assign ctrl.clear    = samples.last_sample;
    assign tap_x[0]      = samples.sample;

    always_comb
    begin
        for (int i = 0; i < NUM_COEF; i++)
        begin
            coef_next[i] = coef_reg[i];
        end
        if (cfg_we)
        begin
            coef_next[cfg_index] = coef_t'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    genvar j;
    generate
        for (j = 0; j < TAPS; j++)
        begin : g_cell
            cff_tap_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .tap_x (tap_x[j]),
                .coef  (coef_reg[j]),
                .samp  (tap_x[j+1]),
                .prod  (cell_prod[j])
            );
        end
    endgenerate

    always_comb
    begin
        for (int k = 0; k < MAX_TAPS; k++)
        begin
            tree_in[k] = '0;
        end
        for (int k = 0; k < TAPS; k++)
        begin
            tree_in[k] = cell_prod[k];
        end
        pv_next = accept ? 1'b1 : (prod_en ? 1'b0 : pv_reg);
        pl_next = accept ? samples.last_sample : pl_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pl_reg <= pl_next;
    end

    cff_add_tree u_tree (
        .clk        (clk),
        .rst_n      (rst_n),
        .prod       (tree_in),
        .prod_valid (pv_reg),
        .prod_last  (pl_reg),
        .prod_en    (prod_en),
        .results    (results)
    );

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && samples.last_sample |=> tap_x[1] == '0)
        else $error("delay line not cleared after last sample");

    a_shift_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !samples.last_sample |=> tap_x[1] == $past(samples.sample))
        else $error("delay line did not take the transferred sample");

    a_prod_valid: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> pv_reg)
        else $error("product stage lost a transferred sample");
`endif

endmodule
